// ===== rtl/core/tmp_pkg.sv =====
// Shared constants and types for the trapezoid motion profile unit.
`timescale 1ns / 1ps
`default_nettype none

package tmp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  typedef enum logic [1:0] {
    PH_ACCEL   = 2'd0,
    PH_CRUISE  = 2'd1,
    PH_DECEL   = 2'd2,
    PH_ARRIVED = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmp_div.sv =====
// Pipelined restoring divider that produces one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module tmp_div #(
  parameter int NW  = 2 * tmp_pkg::DATA_WIDTH,
  parameter int DVW = tmp_pkg::DATA_WIDTH,
  parameter int SW  = 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           ce,
  input  wire logic           in_valid,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DVW-1:0] den,
  input  wire logic [SW-1:0]  side_in,
  output logic                out_valid,
  output logic [NW-1:0]       quo,
  output logic [DVW-1:0]      rem_out,
  output logic [SW-1:0]       side_out
);

  // The numerator register fills with quotient bits from the bottom as it shifts out.
  logic           v  [NW];
  logic [NW-1:0]  nq [NW];
  logic [DVW-1:0] rm [NW];
  logic [DVW-1:0] dv [NW];
  logic [SW-1:0]  sd [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic           cv;
    logic [NW-1:0]  cnq;
    logic [DVW-1:0] crm;
    logic [DVW-1:0] cdv;
    logic [SW-1:0]  csd;
    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign cv  = in_valid;
      assign cnq = num;
      assign crm = '0;
      assign cdv = den;
      assign csd = side_in;
    end else begin : g_next
      assign cv  = v[k-1];
      assign cnq = nq[k-1];
      assign crm = rm[k-1];
      assign cdv = dv[k-1];
      assign csd = sd[k-1];
    end

    assign trial = {crm, cnq[NW-1]};
    assign ge    = trial >= {1'b0, cdv};
    assign diff  = trial - {1'b0, cdv};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (ce) begin
        v[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        nq[k] <= {cnq[NW-2:0], ge};
        rm[k] <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
        dv[k] <= cdv;
        sd[k] <= csd;
      end
    end
  end

  assign out_valid = v[NW-1];
  assign quo       = nq[NW-1];
  assign rem_out   = rm[NW-1];
  assign side_out  = sd[NW-1];

endmodule

`default_nettype wire

// ===== rtl/core/trapezoid_motion_profile_unit.sv =====
// Top level of the trapezoid motion profile unit: a stateless position query pipeline.
`timescale 1ns / 1ps
`default_nettype none
//
// Each item on the slave stream is one query: acceleration, deceleration, a signed
// speed limit, a signed move distance and an elapsed time, all fixed point with
// FRAC_BITS fraction bits. The master stream returns one item per query: the signed
// position on the asymmetric trapezoid (or triangle when the cruise speed is never
// reached), the motion phase, a triangle flag and a flag for a zero speed limit.
// Queries are independent, so a new item is taken in every cycle in which the
// pipeline moves. The pipeline length comes from the three chained dividers (two of
// 2*DATA_WIDTH bit stages, one of DATA_WIDTH+FRAC_BITS stages) and the DATA_WIDTH
// stage square root.
// The whole pipeline advances on one enable: when the output register holds an item
// the receiver has not taken, every stage freezes and s_tready drops; nothing is lost
// or repeated. A synchronous reset clears all valid bits, so the output stream is
// empty after reset; data registers are not reset.
//
module trapezoid_motion_profile_unit #(
  parameter int DATA_WIDTH = tmp_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = tmp_pkg::FRAC_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // accel_rate, decel_rate, speed_limit, move_distance, elapsed_time, zero fill
  input  wire logic [((5*DATA_WIDTH-3+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // position, phase, is_triangular, bad_params, zero fill
  output logic [((DATA_WIDTH+4+7)/8)*8-1:0] m_tdata
);

  import tmp_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FW = FRAC_BITS;
  localparam int UW = DW - 1;
  localparam int NB = 2 * DW;
  localparam int BW = DW + FW;
  localparam int TW = BW + 2;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int MW = UW + BW;
  localparam int PW = DW + BW;
  localparam int OW = ((DW + 4 + 7) / 8) * 8;

  // Everything an item carries along the pipeline; later fields are filled in on the way.
  typedef struct packed {
    logic          neg;
    logic          bad;
    logic          triang;
    logic [UW-1:0] a1;
    logic [UW-1:0] a2;
    logic [UW-1:0] tm;
    logic [DW-1:0] sm;
    logic [DW-1:0] vm;
    logic [DW-1:0] dst;
    logic [DW-1:0] rest;
    logic [NB-1:0] m1;
    logic [BW-1:0] tc;
  } ctx_t;

  localparam int CW = $bits(ctx_t);

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // ---------------------------------------------------------------- input stage
  logic [UW-1:0] a1_in, a2_in, tm_in;
  logic [DW-1:0] spd_in, mov_in;
  ctx_t          c0_next;

  assign a1_in  = s_tdata[UW-1:0];
  assign a2_in  = s_tdata[2*UW-1:UW];
  assign spd_in = s_tdata[2*UW+DW-1:2*UW];
  assign mov_in = s_tdata[2*UW+2*DW-1:2*UW+DW];
  assign tm_in  = s_tdata[3*UW+2*DW-1:2*UW+2*DW];

  always_comb begin
    c0_next     = '0;
    c0_next.a1  = (a1_in == '0) ? UW'(1) : a1_in;
    c0_next.a2  = (a2_in == '0) ? UW'(1) : a2_in;
    c0_next.tm  = tm_in;
    c0_next.neg = spd_in[DW-1];
    c0_next.bad = (spd_in == '0);
    c0_next.vm  = spd_in[DW-1] ? (~spd_in + DW'(1)) : spd_in;
    c0_next.sm  = DW'(c0_next.a1) + DW'(c0_next.a2);
    // A distance pointing against the speed sign, or zero, gives a move of zero length.
    if (mov_in != '0 && mov_in[DW-1] == spd_in[DW-1]) begin
      c0_next.dst = mov_in[DW-1] ? (~mov_in + DW'(1)) : mov_in;
    end
  end

  ctx_t c0;
  logic v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ce) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c0 <= c0_next;
    end
  end

  // ------------------------------------------- squares and numerator products
  ctx_t          c1;
  logic          v1;
  logic [NB-1:0] vsq1, p1;
  logic [NB-1:0] vsq_c, p_c;

  assign vsq_c = c0.vm * c0.vm;
  assign p_c   = {c0.dst, 1'b0} * c0.a1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c1   <= c0;
      vsq1 <= vsq_c;
      p1   <= p_c;
    end
  end

  // ---------------- braking distances d1, d2 and the first triangle quotient
  logic [NB-1:0] d1q, d2q, qq;
  logic [DW-1:0] qr;
  logic [CW-1:0] cb_raw;
  logic          vb;
  ctx_t          cb;

  tmp_div #(.NW(NB), .DVW(DW), .SW(1)) u_div_d1 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v1),
    .num({1'b0, vsq1[NB-1:1]}), .den({1'b0, c1.a1}), .side_in(1'b0),
    .out_valid(), .quo(d1q), .rem_out(), .side_out()
  );

  tmp_div #(.NW(NB), .DVW(DW), .SW(1)) u_div_d2 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v1),
    .num({1'b0, vsq1[NB-1:1]}), .den({1'b0, c1.a2}), .side_in(1'b0),
    .out_valid(), .quo(d2q), .rem_out(), .side_out()
  );

  tmp_div #(.NW(NB), .DVW(DW), .SW(CW)) u_div_q (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v1),
    .num(p1), .den(c1.sm), .side_in(c1),
    .out_valid(vb), .quo(qq), .rem_out(qr), .side_out(cb_raw)
  );

  assign cb = ctx_t'(cb_raw);

  // ----------------------------- triangle test, cruise length, peak-speed terms
  ctx_t          c2_next, c2;
  logic          v2;
  logic [NB-1:0] dsum, rn_c, rn2;

  assign dsum = d1q + d2q;
  assign rn_c = qr * cb.a2;

  always_comb begin
    c2_next        = cb;
    c2_next.triang = NB'(cb.dst) < dsum;
    c2_next.rest   = cb.dst - d1q[DW-1:0] - d2q[DW-1:0];
    c2_next.m1     = qq[DW:0] * cb.a2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c2  <= c2_next;
      rn2 <= rn_c;
    end
  end

  // ------------------------ remainder correction and cruise time division
  logic [NB-1:0] eq, cq;
  logic [CW-1:0] cd_raw;
  logic          vd;
  ctx_t          cd;

  tmp_div #(.NW(NB), .DVW(DW), .SW(CW)) u_div_e (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v2),
    .num(rn2), .den(c2.sm), .side_in(c2),
    .out_valid(vd), .quo(eq), .rem_out(), .side_out(cd_raw)
  );

  tmp_div #(.NW(NB), .DVW(DW), .SW(1)) u_div_c (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v2),
    .num(NB'({c2.rest, {FW{1'b0}}})), .den(c2.vm), .side_in(1'b0),
    .out_valid(), .quo(cq), .rem_out(), .side_out()
  );

  assign cd = ctx_t'(cd_raw);

  ctx_t          c3_next, c3;
  logic          v3;
  logic [NB-1:0] rad3;

  always_comb begin
    c3_next    = cd;
    c3_next.tc = cq[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c3    <= c3_next;
      rad3  <= cd.m1 + eq;
    end
  end

  // ------------------------------- square root of vp^2, one root bit per stage
  logic          sq_v    [DW];
  logic [DW+1:0] sq_rem  [DW];
  logic [NB-1:0] sq_rad  [DW];
  logic [DW-1:0] sq_root [DW];
  ctx_t          sq_ctx  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    logic          cv;
    logic [DW+1:0] crem;
    logic [NB-1:0] crad;
    logic [DW-1:0] croot;
    ctx_t          cctx;
    logic [DW+3:0] cand, trial, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign cv    = v3;
      assign crem  = '0;
      assign crad  = rad3;
      assign croot = '0;
      assign cctx  = c3;
    end else begin : g_next
      assign cv    = sq_v[k-1];
      assign crem  = sq_rem[k-1];
      assign crad  = sq_rad[k-1];
      assign croot = sq_root[k-1];
      assign cctx  = sq_ctx[k-1];
    end

    assign cand  = {crem, crad[NB-1:NB-2]};
    assign trial = {2'b00, croot, 2'b01};
    assign ge    = cand >= trial;
    assign diff  = cand - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (ce) begin
        sq_v[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sq_rem[k]  <= ge ? diff[DW+1:0] : cand[DW+1:0];
        sq_rad[k]  <= {crad[NB-3:0], 2'b00};
        sq_root[k] <= {croot[DW-2:0], ge};
        sq_ctx[k]  <= cctx;
      end
    end
  end

  // ------------------------- pick the speed that sets the ramp times
  ctx_t          c4;
  logic          v4;
  logic [BW-1:0] num4;
  logic [DW-1:0] nv;

  assign nv = sq_ctx[DW-1].triang ? sq_root[DW-1] : sq_ctx[DW-1].vm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ce) begin
      v4 <= sq_v[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c4   <= sq_ctx[DW-1];
      num4 <= {nv, {FW{1'b0}}};
    end
  end

  // ------------------------------------------ ramp-up and ramp-down durations
  logic [BW-1:0] q1, q3;
  logic [CW-1:0] ci_raw;
  logic          vi;
  ctx_t          ci;

  tmp_div #(.NW(BW), .DVW(DW), .SW(CW)) u_div_t1 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v4),
    .num(num4), .den({1'b0, c4.a1}), .side_in(c4),
    .out_valid(vi), .quo(q1), .rem_out(), .side_out(ci_raw)
  );

  tmp_div #(.NW(BW), .DVW(DW), .SW(1)) u_div_t3 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v4),
    .num(num4), .den({1'b0, c4.a2}), .side_in(1'b0),
    .out_valid(), .quo(q3), .rem_out(), .side_out()
  );

  assign ci = ctx_t'(ci_raw);

  // ------------------------------------------------------ phase boundaries
  ctx_t          c5;
  logic          v5;
  logic [TW-1:0] t1_5, t2_5, t3_5;
  logic [TW-1:0] t2_c;

  // A triangle has no cruise, so its second boundary equals the first.
  assign t2_c = ci.triang ? TW'(q1) : TW'(q1) + TW'(ci.tc);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (ce) begin
      v5 <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c5   <= ci;
      t1_5 <= TW'(q1);
      t2_5 <= t2_c;
      t3_5 <= t2_c + TW'(q3);
    end
  end

  // ---------------------------------------- phase decision and first operands
  ctx_t          c6;
  logic          v6;
  phase_t        ph_c, ph6;
  logic [UW-1:0] ma6;
  logic [BW-1:0] mb6, cr6;
  logic [TW-1:0] tw5, rt5, cr5;

  assign tw5 = TW'(c5.tm);
  assign rt5 = t3_5 - tw5;
  assign cr5 = TW'({c5.tm, 1'b0}) - t1_5;

  // The triangle uses strict bounds, the trapezoid inclusive ones.
  always_comb begin
    if (c5.triang) begin
      if (tw5 < t1_5) begin
        ph_c = PH_ACCEL;
      end else if (tw5 < t3_5) begin
        ph_c = PH_DECEL;
      end else begin
        ph_c = PH_ARRIVED;
      end
    end else begin
      if (tw5 <= t1_5) begin
        ph_c = PH_ACCEL;
      end else if (tw5 <= t2_5) begin
        ph_c = PH_CRUISE;
      end else if (tw5 <= t3_5) begin
        ph_c = PH_DECEL;
      end else begin
        ph_c = PH_ARRIVED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (ce) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c6  <= c5;
      ph6 <= ph_c;
      ma6 <= (ph_c == PH_ACCEL) ? c5.a1 : c5.a2;
      mb6 <= (ph_c == PH_ACCEL) ? BW'(c5.tm) : rt5[BW-1:0];
      cr6 <= cr5[BW-1:0];
    end
  end

  // ------------------------------- velocity product, split in two halves
  ctx_t             c7;
  logic             v7;
  phase_t           ph7;
  logic [BW-1:0]    mb7, cr7;
  logic [UW+BL-1:0] pl7;
  logic [UW+BH-1:0] phi7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (ce) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c7   <= c6;
      ph7  <= ph6;
      mb7  <= mb6;
      cr7  <= cr6;
      pl7  <= ma6 * mb6[BL-1:0];
      phi7 <= ma6 * mb6[BW-1:BL];
    end
  end

  // ------------------------------ velocity and the second product's operands
  ctx_t          c8;
  logic          v8;
  phase_t        ph8;
  logic [MW-1:0] vprod;
  logic [DW-1:0] vel, a8;
  logic [BW-1:0] b8;

  assign vprod = MW'(pl7) + (MW'(phi7) << BL);
  assign vel   = vprod[FW +: DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (ce) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c8  <= c7;
      ph8 <= ph7;
      a8  <= (ph7 == PH_CRUISE) ? c7.vm : vel;
      b8  <= (ph7 == PH_CRUISE) ? cr7 : mb7;
    end
  end

  // ------------------------------------------- distance product halves
  ctx_t             c9;
  logic             v9;
  phase_t           ph9;
  logic [DW+BL-1:0] ql9;
  logic [DW+BH-1:0] qh9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (ce) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c9  <= c8;
      ph9 <= ph8;
      ql9 <= a8 * b8[BL-1:0];
      qh9 <= a8 * b8[BW-1:BL];
    end
  end

  // --------------------------------- position, clamp, sign and output register
  logic [PW-1:0] dprod, sh, dp, pv, pc;
  logic [DW-1:0] pos_mag, pos_c;

  assign dprod = PW'(ql9) + (PW'(qh9) << BL);
  assign sh    = dprod >> (FW + 1);
  assign dp    = PW'(c9.dst);

  always_comb begin
    case (ph9)
      PH_ACCEL, PH_CRUISE: pv = sh;
      PH_DECEL:            pv = (sh < dp) ? (dp - sh) : '0;
      default:             pv = dp;
    endcase
    pc      = (pv > dp) ? dp : pv;
    pos_mag = pc[DW-1:0];
    pos_c   = c9.neg ? (~pos_mag + DW'(1)) : pos_mag;
  end

  logic [DW-1:0] o_pos;
  phase_t        o_phase;
  logic          o_triang, o_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (c9.bad) begin
        o_pos    <= '0;
        o_phase  <= PH_ARRIVED;
        o_triang <= 1'b0;
        o_bad    <= 1'b1;
      end else begin
        o_pos    <= pos_c;
        o_phase  <= ph9;
        o_triang <= c9.triang;
        o_bad    <= 1'b0;
      end
    end
  end

  assign m_tdata = OW'({o_bad, o_triang, o_phase, o_pos});

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the trapezoid motion profile unit.
`timescale 1ns / 1ps

module tb_top;
  import tmp_pkg::*;

  localparam int LATENCY_WAIT  = 300;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_QUERIES = 1700;
  localparam int HOLD_OFF_LEN  = 1500;
  localparam int HOLD_OFF_AT   = 300;

  typedef struct packed {
    logic [30:0] accel;
    logic [30:0] decel;
    logic [31:0] speed;
    logic [31:0] move_dist;
    logic [30:0] etime;
  } query_t;

  typedef struct packed {
    logic [31:0] position;
    phase_t      phase;
    logic        tri_flag;
    logic        bad_flag;
  } motion_t;

  // One row of the directed table; the expectation is typed in only when use_typed is set.
  typedef struct {
    query_t  q;
    bit      use_typed;
    motion_t typed;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;

  motion_t expected_positions[$];
  int      failures = 0;
  int      received = 0;
  bit      stimulus_done = 1'b0;
  bit      burst_mode = 1'b0;
  int      quiet_cycles = 0;

  always #5 clk = ~clk;

  trapezoid_motion_profile_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // accel_rate, decel_rate, speed_limit, move_distance, elapsed_time
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // position, phase, is_triangular, bad_params
  );

  function automatic logic [127:0] root_floor(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (128'(1) << b);
      if (c * c <= n) res = c;
    end
    return res;
  endfunction

  // Position on the asymmetric trapezoid (or triangle) at the queried time.
  function automatic motion_t profile_position(input query_t q);
    logic [127:0] a1, a2, vm, dd, tt, vsq, d1, d2, t1, t2, t3, vp, vel, pos, r, drop;
    logic [31:0] vm32, dd32;
    bit neg, tri_shape, in_accel;
    motion_t m;
    a1 = (q.accel == 0) ? 128'(1) : 128'(q.accel);
    a2 = (q.decel == 0) ? 128'(1) : 128'(q.decel);
    tt = 128'(q.etime);
    m.bad_flag = 1'b0;
    if (q.speed == 0) begin
      m.position = '0;
      m.phase    = PH_ARRIVED;
      m.tri_flag = 1'b0;
      m.bad_flag = 1'b1;
      return m;
    end
    neg  = q.speed[31];
    vm32 = neg ? (~q.speed + 32'd1) : q.speed;
    vm   = 128'(vm32);
    // A distance pointing against the direction of travel collapses the move to zero.
    dd32 = '0;
    if (q.move_dist != 0 && q.move_dist[31] == neg) begin
      dd32 = neg ? (~q.move_dist + 32'd1) : q.move_dist;
    end
    dd  = 128'(dd32);
    vsq = vm * vm;
    d1  = vsq / (2 * a1);
    d2  = vsq / (2 * a2);
    tri_shape = dd < d1 + d2;
    if (tri_shape) begin
      vp = root_floor((2 * dd * a1 * a2) / (a1 + a2));
      t1 = (vp << FRAC_BITS) / a1;
      t2 = t1;
      t3 = t1 + (vp << FRAC_BITS) / a2;
    end else begin
      t1 = (vm << FRAC_BITS) / a1;
      t2 = t1 + ((dd - d1 - d2) << FRAC_BITS) / vm;
      t3 = t2 + (vm << FRAC_BITS) / a2;
    end
    in_accel = tri_shape ? (tt < t1) : (tt <= t1);
    if (in_accel) begin
      vel = ((a1 * tt) >> FRAC_BITS) & 128'({64{1'b1}});
      pos = (tt * vel) >> (FRAC_BITS + 1);
      m.phase = PH_ACCEL;
    end else if (!tri_shape && tt <= t2) begin
      pos = ((2 * tt - t1) * vm) >> (FRAC_BITS + 1);
      m.phase = PH_CRUISE;
    end else if (tri_shape ? (tt < t3) : (tt <= t3)) begin
      r    = t3 - tt;
      vel  = ((r * a2) >> FRAC_BITS) & 128'({64{1'b1}});
      drop = (r * vel) >> (FRAC_BITS + 1);
      pos  = (drop < dd) ? dd - drop : '0;
      m.phase = PH_DECEL;
    end else begin
      pos = dd;
      m.phase = PH_ARRIVED;
    end
    if (pos > dd) pos = dd;
    m.position = neg ? -pos[31:0] : pos[31:0];
    m.tri_flag = tri_shape;
    return m;
  endfunction

  // Realistic moves most of the time, raw noise over every bit for the rest.
  function automatic query_t random_query();
    query_t q;
    logic [31:0] mag;
    if ($urandom_range(0, 7) == 0) begin
      q.accel     = 31'($urandom);
      q.decel     = 31'($urandom);
      q.speed     = $urandom;
      q.move_dist = $urandom;
      q.etime     = 31'($urandom);
      return q;
    end
    q.accel     = 31'($urandom_range(1, 255) << $urandom_range(8, 22));
    q.decel     = 31'($urandom_range(1, 255) << $urandom_range(8, 22));
    q.speed     = $urandom_range(1, 255) << $urandom_range(10, 20);
    q.move_dist = $urandom_range(1, 255) << $urandom_range(12, 22);
    q.etime     = 31'($urandom_range(0, 1023) << $urandom_range(6, 20));
    if ($urandom_range(0, 1)) begin
      q.speed = -q.speed;
      mag = q.move_dist;
      q.move_dist = -mag;
    end
    if ($urandom_range(0, 15) == 0) q.move_dist = -q.move_dist;
    return q;
  endfunction

  task automatic send_query(input query_t q, input motion_t exp_m);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    s_tvalid = 1'b0;
    repeat (gap) @(negedge clk);
    s_tdata  = {3'b000, q.etime, q.move_dist, q.speed, q.decel, q.accel};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_positions.push_back(exp_m);
    @(negedge clk);
  endtask

  // Query source: directed table first, then random moves.
  initial begin
    row_t rows[$];
    row_t rw;
    query_t q;
    motion_t zero_v;
    zero_v = '{position: '0, phase: PH_ARRIVED, tri_flag: 1'b0, bad_flag: 1'b1};
    rw.use_typed = 1'b0;
    rw.typed = zero_v;
    // Zero speed limit, typed in directly.
    rw.q = '{31'h10000, 31'h10000, 32'h0, 32'h00100000, 31'h40000};
    rw.use_typed = 1'b1; rows.push_back(rw);
    rw.q = '{31'h7fffffff, 31'h0, 32'h0, 32'h80000000, 31'h7fffffff};
    rows.push_back(rw);
    rw.use_typed = 1'b0;
    // Trapezoid walked through every phase.
    rw.q = '{31'h20000, 31'h10000, 32'h20000, 32'h00100000, 31'h0};     rows.push_back(rw);
    rw.q = '{31'h20000, 31'h10000, 32'h20000, 32'h00100000, 31'h8000};  rows.push_back(rw);
    rw.q = '{31'h20000, 31'h10000, 32'h20000, 32'h00100000, 31'h30000}; rows.push_back(rw);
    rw.q = '{31'h20000, 31'h10000, 32'h20000, 32'h00100000, 31'h88000}; rows.push_back(rw);
    rw.q = '{31'h20000, 31'h10000, 32'h20000, 32'h00100000, 31'h100000}; rows.push_back(rw);
    // Triangle: distance too short for the limit.
    rw.q = '{31'h10000, 31'h30000, 32'h100000, 32'h00010000, 31'h4000};  rows.push_back(rw);
    rw.q = '{31'h10000, 31'h30000, 32'h100000, 32'h00010000, 31'h14000}; rows.push_back(rw);
    rw.q = '{31'h10000, 31'h30000, 32'h100000, 32'h00010000, 31'h40000}; rows.push_back(rw);
    // Negative direction, most negative speed and distance.
    rw.q = '{31'h20000, 31'h20000, 32'hfffe0000, 32'hfff00000, 31'h30000}; rows.push_back(rw);
    rw.q = '{31'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h80000000, 31'h7fffffff};
    rows.push_back(rw);
    rw.q = '{31'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h80000000, 31'h100};
    rows.push_back(rw);
    // Distance against the direction, and zero distance.
    rw.q = '{31'h20000, 31'h20000, 32'h20000, 32'hfff00000, 31'h30000}; rows.push_back(rw);
    rw.q = '{31'h20000, 31'h20000, 32'hfffe0000, 32'h00100000, 31'h30000}; rows.push_back(rw);
    rw.q = '{31'h20000, 31'h20000, 32'h20000, 32'h0, 31'h30000};          rows.push_back(rw);
    // Zero rates are used as one LSB.
    rw.q = '{31'h0, 31'h0, 32'h1, 32'h7fffffff, 31'h7fffffff};   rows.push_back(rw);
    rw.q = '{31'h0, 31'h10000, 32'h10000, 32'h7fffffff, 31'h10000}; rows.push_back(rw);
    // Largest positive values everywhere, then with a deceleration of one LSB.
    rw.q = '{31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff};
    rows.push_back(rw);
    rw.q = '{31'h7fffffff, 31'h1, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff};
    rows.push_back(rw);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (rows[i])
      send_query(rows[i].q, rows[i].use_typed ? rows[i].typed : profile_position(rows[i].q));
    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      // Stretches without any idling on either side.
      if (n % 150 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      q = random_query();
      send_query(q, profile_position(q));
    end
    s_tvalid = 1'b0;
    stimulus_done = 1'b1;
  end

  // Result sink with random back-pressure and one long hold-off that fills the pipeline.
  initial begin
    int gap;
    bit held = 1'b0;
    @(negedge clk);
    while (1) begin
      if (!held && received == HOLD_OFF_AT) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk);
      end
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      m_tready = 1'b0;
      repeat (gap) @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    motion_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], phase_t'(m_tdata[33:32]), m_tdata[34], m_tdata[35]};
      received <= received + 1;
      if (expected_positions.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, actual %h", $time, got);
      end else begin
        want = expected_positions.pop_front();
        if (got.position !== want.position) begin
          failures++;
          $display("%0t: position expected %h actual %h", $time, want.position, got.position);
        end
        if (got.phase !== want.phase) begin
          failures++;
          $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
        end
        if (got.tri_flag !== want.tri_flag) begin
          failures++;
          $display("%0t: is_triangular expected %b actual %b", $time, want.tri_flag,
                   got.tri_flag);
        end
        if (got.bad_flag !== want.bad_flag) begin
          failures++;
          $display("%0t: bad_params expected %b actual %b", $time, want.bad_flag,
                   got.bad_flag);
        end
      end
    end
  end

  // Watchdog: too many cycles with no item moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    wait (expected_positions.size() == 0);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (failures == 0 && expected_positions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tmp_pkg.sv
rtl/core/tmp_div.sv
rtl/core/trapezoid_motion_profile_unit.sv
verif/tb_top.sv
